@@ hdl/dfrc_pkg.sv @@
// package for the download frame receiver and checker
// holds the frame layout constants, the result item type and the checksum fold
// no dependencies
`default_nettype none

package dfrc_pkg;

   localparam int unsigned CMD_BYTES = 2;

   localparam logic [31:0] MAGIC_RESET = 32'h5C6D_8E9F;

   localparam logic [16:0] IDX_LENGTH  = 17'd4;
   localparam logic [16:0] IDX_COMMAND = 17'd6;
   localparam logic [16:0] HDR_BYTES   = 17'(6 + CMD_BYTES);

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_offset;
      logic [15:0] command_code;
      logic [15:0] payload_length;
      logic        checksum_bad;
      logic        magic_bad;
   } dfrc_result_type;

   // end-around carry fold, then complement
   function automatic logic [15:0] fold_sum(input logic [31:0] sum);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, sum[31:16]} + {1'b0, sum[15:0]};
      s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
      return ~s2[15:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/dfrc_parser.sv @@
// frame parser: hunt, header collection, checksum accumulation and verdict
// one item is processed per step, result formed combinationally
// depends on dfrc_pkg
`default_nettype none

module dfrc_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               rx_byte,
   input  wire logic [31:0]              expected_magic,
   output logic                          res_valid,
   output dfrc_pkg::dfrc_result_type     res
);
   import dfrc_pkg::*;

   logic        hunting_ff, hunting_in;
   logic [16:0] byte_count_ff, byte_count_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] command_ff, command_in;
   logic [31:0] sum_ff, sum_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  check_low_ff, check_low_in;

   logic [16:0] idx;
   logic [16:0] pay_end;
   logic [31:0] addend;
   logic [15:0] got;

   assign idx     = byte_count_ff;
   assign pay_end = HDR_BYTES + {1'b0, length_ff};
   assign got     = {rx_byte, check_low_ff};

   always_comb begin
      hunting_in    = hunting_ff;
      byte_count_in = byte_count_ff;
      magic_in      = magic_ff;
      length_in     = length_ff;
      command_in    = command_ff;
      sum_in        = sum_ff;
      low_in        = low_ff;
      check_low_in  = check_low_ff;
      addend        = '0;
      res_valid     = 1'b0;
      res.item_kind      = KIND_PAYLOAD;
      res.payload_byte   = rx_byte;
      res.payload_offset = 16'(idx - HDR_BYTES);
      res.command_code   = command_ff;
      res.payload_length = length_ff;
      res.checksum_bad   = 1'b0;
      res.magic_bad      = 1'b0;

      if (hunting_ff) begin
         if (rx_byte == expected_magic[7:0]) begin
            hunting_in    = 1'b0;
            byte_count_in = 17'd1;
            magic_in      = {24'b0, rx_byte};
            length_in     = '0;
            command_in    = '0;
            sum_in        = '0;
            low_in        = '0;
            check_low_in  = '0;
         end
      end else begin
         byte_count_in = byte_count_ff + 17'd1;

         // word accumulation over length, command and payload
         if (idx >= IDX_LENGTH && idx < pay_end) begin
            if (!idx[0]) begin
               low_in = rx_byte;
            end else begin
               addend = {16'b0, rx_byte, low_ff};
            end
         end else if (idx == pay_end && length_ff[0] == (CMD_BYTES % 2 == 0 ? 1'b1 : 1'b0)) begin
            // odd trailing byte added alone
            addend = {24'b0, low_ff};
         end
         sum_in = sum_ff + addend;

         if (idx < IDX_LENGTH) begin
            magic_in[8*idx[1:0] +: 8] = rx_byte;
         end else if (idx < IDX_COMMAND) begin
            length_in[8*idx[0] +: 8] = rx_byte;
         end else if (idx < HDR_BYTES) begin
            command_in[8*idx[0] +: 8] = rx_byte;
         end else if (idx < pay_end) begin
            res_valid = 1'b1;
         end else if (idx == pay_end) begin
            check_low_in = rx_byte;
         end else begin
            res_valid          = 1'b1;
            res.item_kind      = KIND_VERDICT;
            res.payload_byte   = '0;
            res.payload_offset = '0;
            res.checksum_bad   = (got != fold_sum(sum_ff));
            res.magic_bad      = (magic_ff != expected_magic);
            hunting_in         = 1'b1;
            byte_count_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff    <= 1'b1;
         byte_count_ff <= '0;
      end else if (step) begin
         hunting_ff    <= hunting_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         magic_ff     <= magic_in;
         length_ff    <= length_in;
         command_ff   <= command_in;
         sum_ff       <= sum_in;
         low_ff       <= low_in;
         check_low_ff <= check_low_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/dfrc_out_reg.sv @@
// result register: holds one result item until the receiver takes it
// depends on dfrc_pkg
`default_nettype none

module dfrc_out_reg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire dfrc_pkg::dfrc_result_type load_item,
   input  wire logic                     rsp_stall,
   output logic                          free,
   output logic                          rsp_valid,
   output dfrc_pkg::dfrc_result_type     rsp_item
);
   import dfrc_pkg::*;

   logic            valid_ff, valid_in;
   dfrc_result_type item_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = free ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         item_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

@@ hdl/download_frame_receiver_checker_unit.sv @@
// top level of the download frame receiver and checker
// depends on dfrc_pkg, dfrc_parser and dfrc_out_reg
//
// usage:
//   req channel carries one received serial byte per item (req_rx_byte).
//   rsp channel carries one result item: a payload byte with its offset
//   (item_kind 0) or the end of frame verdict (item_kind 1) with command,
//   length and the checksum and magic mismatch flags.
//   csr_write_enable / csr_write_data load the expected magic word; its low
//   byte is the byte that starts a frame. write only while no item is in flight.
//   flow: a byte accepted at a rising edge sits in the input register; its
//   result is loaded into the result register once that register is free,
//   and rsp_valid is driven from that register. throughput: one byte per cycle
//   while rsp_stall holds no waiting result. the single 32-bit checksum adder
//   and the header compare lie between the two registers. bytes that give no
//   result pass without using the rsp channel.
//   reset (synchronous) returns to hunting, empties both registers and loads
//   the expected magic with 0x5C6D8E9F.
//   when rsp_stall holds a waiting result, one more byte is taken into the
//   input register and req_stall then rises until the result is taken.
`default_nettype none

module download_frame_receiver_checker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_payload_offset,
   output logic [15:0]      rsp_command_code,
   output logic [15:0]      rsp_payload_length,
   output logic             rsp_checksum_bad,
   output logic             rsp_magic_bad,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);
   import dfrc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic [31:0]     magic_cfg_ff;
   logic            out_free;
   logic            step;
   logic            res_valid;
   dfrc_result_type res;
   dfrc_result_type rsp_item;

   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         magic_cfg_ff <= MAGIC_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            magic_cfg_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   dfrc_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .rx_byte        (in_byte_ff),
      .expected_magic (magic_cfg_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   dfrc_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && res_valid),
      .load_item (res),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_item_kind      = rsp_item.item_kind;
   assign rsp_payload_byte   = rsp_item.payload_byte;
   assign rsp_payload_offset = rsp_item.payload_offset;
   assign rsp_command_code   = rsp_item.command_code;
   assign rsp_payload_length = rsp_item.payload_length;
   assign rsp_checksum_bad   = rsp_item.checksum_bad;
   assign rsp_magic_bad      = rsp_item.magic_bad;

endmodule

`default_nettype wire

@@ hdl/dfrc_checker.sv @@
// port-level checks for download_frame_receiver_checker_unit, attached by bind
// depends on dfrc_pkg
`default_nettype none

module dfrc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_item_kind,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic [15:0] rsp_payload_offset,
   input wire logic        rsp_checksum_bad,
   input wire logic        rsp_magic_bad
);
   import dfrc_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // payload items never carry verdict flags
   a_payload_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == KIND_PAYLOAD) |-> (!rsp_checksum_bad && !rsp_magic_bad))
      else $error("verdict flag on payload item");

   // verdict items carry zero byte and offset
   a_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == KIND_VERDICT)
         |-> (rsp_payload_byte == 8'd0 && rsp_payload_offset == 16'd0))
      else $error("verdict item with payload data");

   // a stalled result stays put
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_offset)))
      else $error("stalled result changed");

endmodule

bind download_frame_receiver_checker_unit dfrc_checker u_dfrc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_item_kind      (rsp_item_kind),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_offset (rsp_payload_offset),
   .rsp_checksum_bad   (rsp_checksum_bad),
   .rsp_magic_bad      (rsp_magic_bad)
);

`default_nettype wire
